>>> rtl/core/bod_pkg.sv
package bod_pkg;

  // Default coordinate width (Q7.8 fixed point: 16 bits, 8 of them fraction)
  localparam int COORD_WIDTH_DEF = 16;

  // Configuration register index
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTRE_X      = 2'd0,
    REG_CENTRE_Y      = 2'd1,
    REG_HALF_EXTENT_X = 2'd2,
    REG_HALF_EXTENT_Y = 2'd3
  } bod_reg_t;

  // Control that travels down the pipeline beside each word
  typedef struct packed {
    logic valid;
    logic last;
  } bod_ctl_t;

endpackage

>>> rtl/core/bod_offset.sv
// Two stages: absolute offset from the centre, then minus half extent, clamped at zero.
module bod_offset #(
  parameter int W = bod_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [W-1:0]  centre_x,
  input  logic signed [W-1:0]  centre_y,
  input  logic [W-2:0]         half_x,
  input  logic [W-2:0]         half_y,
  input  bod_pkg::bod_ctl_t    up_ctl,
  output logic                 up_ready,
  input  logic signed [W-1:0]  point_x,
  input  logic signed [W-1:0]  point_y,
  output bod_pkg::bod_ctl_t    dn_ctl,
  input  logic                 dn_ready,
  output logic [W-1:0]         dx,
  output logic [W-1:0]         dy
);
  import bod_pkg::*;

  bod_ctl_t     ctl_a_r, ctl_b_r;
  logic [W-1:0] absx_r, absy_r, absx_nxt, absy_nxt;
  logic [W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic         ready_a, ready_b;

  // |p - c|: both differences in parallel, pick by sign
  function automatic logic [W-1:0] abs_diff(input logic [W-1:0] p, input logic [W-1:0] c);
    logic [W:0] pc;
    logic [W:0] cp;
    begin
      pc = {p[W-1], p} - {c[W-1], c};
      cp = {c[W-1], c} - {p[W-1], p};
      abs_diff = pc[W] ? cp[W-1:0] : pc[W-1:0];
    end
  endfunction

  // a - h, clamped at zero
  function automatic logic [W-1:0] clamp_sub(input logic [W-1:0] a, input logic [W-2:0] h);
    logic [W:0] r;
    begin
      r = {1'b0, a} - {2'b00, h};
      clamp_sub = r[W] ? '0 : r[W-1:0];
    end
  endfunction

  // stage ready: empty, or the next stage moves on
  assign ready_b  = !ctl_b_r.valid || dn_ready;
  assign ready_a  = !ctl_a_r.valid || ready_b;
  assign up_ready = ready_a;

  assign absx_nxt = abs_diff(point_x, centre_x);
  assign absy_nxt = abs_diff(point_y, centre_y);
  assign dx_nxt   = clamp_sub(absx_r, half_x);
  assign dy_nxt   = clamp_sub(absy_r, half_y);

  // advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      if (ready_a) ctl_a_r <= up_ctl;
      if (ready_b) ctl_b_r <= ctl_a_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (ready_a && up_ctl.valid) begin
      absx_r <= absx_nxt;
      absy_r <= absy_nxt;
    end
    if (ready_b && ctl_a_r.valid) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  assign dn_ctl = ctl_b_r;
  assign dx     = dx_r;
  assign dy     = dy_r;

endmodule

>>> rtl/core/bod_square_sum.sv
// Two stages: square each axis offset, then add the squares.
module bod_square_sum #(
  parameter int W = bod_pkg::COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bod_pkg::bod_ctl_t up_ctl,
  output logic              up_ready,
  input  logic [W-1:0]      dx,
  input  logic [W-1:0]      dy,
  output bod_pkg::bod_ctl_t dn_ctl,
  input  logic              dn_ready,
  output logic [2*W:0]      sum
);
  import bod_pkg::*;

  bod_ctl_t       ctl_c_r, ctl_d_r;
  logic [2*W-1:0] sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic [2*W:0]   sum_r, sum_nxt;
  logic           ready_c, ready_d;

  assign ready_d  = !ctl_d_r.valid || dn_ready;
  assign ready_c  = !ctl_c_r.valid || ready_d;
  assign up_ready = ready_c;

  assign sqx_nxt = {{W{1'b0}}, dx} * {{W{1'b0}}, dx};
  assign sqy_nxt = {{W{1'b0}}, dy} * {{W{1'b0}}, dy};
  assign sum_nxt = {1'b0, sqx_r} + {1'b0, sqy_r};

  // advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r <= '0;
      ctl_d_r <= '0;
    end else begin
      if (ready_c) ctl_c_r <= up_ctl;
      if (ready_d) ctl_d_r <= ctl_c_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (ready_c && up_ctl.valid) begin
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
    end
    if (ready_d && ctl_c_r.valid) begin
      sum_r <= sum_nxt;
    end
  end

  assign dn_ctl = ctl_d_r;
  assign sum    = sum_r;

endmodule

>>> rtl/core/bod_sqrt.sv
// Floor square root, restoring method, one root bit per pipeline stage.
module bod_sqrt #(
  parameter int W = bod_pkg::COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bod_pkg::bod_ctl_t up_ctl,
  output logic              up_ready,
  input  logic [2*W:0]      radicand,
  output bod_pkg::bod_ctl_t dn_ctl,
  input  logic              dn_ready,
  output logic [W:0]        root
);
  import bod_pkg::*;

  localparam int N  = W + 1;     // root bits, one stage each
  localparam int RW = W + 2;     // remainder width
  localparam int AW = 2 * W + 2; // radicand padded to whole bit pairs

  bod_ctl_t      ctl_r  [N];
  logic [RW-1:0] rem_r  [N];
  logic [W:0]    root_r [N];
  logic [AW-1:0] rad_r  [N];

  bod_ctl_t      src_ctl  [N];
  logic [RW-1:0] src_rem  [N];
  logic [W:0]    src_root [N];
  logic [AW-1:0] src_rad  [N];

  logic [N:0]    rdy;

  assign rdy[N]   = dn_ready;
  assign up_ready = rdy[0];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [W+3:0]  cand, trial, diff;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [W:0]    root_nxt;
    logic [AW-1:0] rad_nxt;

    // feed from the input or the previous stage
    if (i == 0) begin : g_first
      assign src_ctl[i]  = up_ctl;
      assign src_rem[i]  = '0;
      assign src_root[i] = '0;
      assign src_rad[i]  = {1'b0, radicand};
    end else begin : g_next
      assign src_ctl[i]  = ctl_r[i-1];
      assign src_rem[i]  = rem_r[i-1];
      assign src_root[i] = root_r[i-1];
      assign src_rad[i]  = rad_r[i-1];
    end

    // bring down the next bit pair and try root*4+1
    assign cand     = {src_rem[i], src_rad[i][AW-1:AW-2]};
    assign trial    = {1'b0, src_root[i], 2'b01};
    assign diff     = cand - trial;
    assign ge       = (cand >= trial);
    assign rem_nxt  = ge ? diff[RW-1:0] : cand[RW-1:0];
    assign root_nxt = {src_root[i][W-1:0], ge};
    assign rad_nxt  = {src_rad[i][AW-3:0], 2'b00};

    assign rdy[i] = !ctl_r[i].valid || rdy[i+1];

    // advance control
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (rdy[i]) begin
        ctl_r[i] <= src_ctl[i];
      end
    end

    // advance payload
    always_ff @(posedge clk) begin
      if (rdy[i] && src_ctl[i].valid) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        rad_r[i]  <= rad_nxt;
      end
    end
  end

  assign dn_ctl = ctl_r[N-1];
  assign root   = root_r[N-1];

endmodule

>>> rtl/core/box_obstacle_distance_core.sv
// Distance from a 2-D point to an axis-aligned box obstacle. Each input word
// carries one signed fixed-point point (x in the low half of in_tdata, y
// above it); the result word carries floor(sqrt(dx^2 + dy^2)), where dx and dy
// are the absolute offsets from the configured box centre less the half
// extents, clamped at zero. The result is in the same fraction format as the
// inputs (Q.8 for the default Q7.8), and tlast passes through with each word.
// The block takes one word per clock and keeps going while a result waits, up
// to the pipeline's depth. Two stages form the clamped offsets, two square and
// add, and the square root settles one result bit per stage over
// COORD_WIDTH + 1 stages. Write the box registers only while no word is in
// flight.
module box_obstacle_distance_core #(
  parameter int  COORD_WIDTH = bod_pkg::COORD_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((COORD_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_TDATA_W-1:0]           in_tdata,   // point_x, point_y, zero pad
  input  logic                            in_tlast,   // point_last
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_TDATA_W-1:0]          out_tdata,  // distance, zero pad
  output logic                            out_tlast,  // distance_last
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [bod_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_wdata
);
  import bod_pkg::*;

  localparam int W = COORD_WIDTH;

  logic [W-1:0] centre_x_r, centre_y_r;
  logic [W-2:0] half_x_r, half_y_r;

  bod_ctl_t     in_ctl, off_ctl, sq_ctl, rt_ctl;
  logic         off_ready, sq_ready;
  logic [W-1:0] dx, dy;
  logic [2*W:0] sum;
  logic [W:0]   distance;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
      half_x_r   <= '0;
      half_y_r   <= '0;
    end else if (cfg_wr_en) begin
      case (bod_reg_t'(cfg_index))
        REG_CENTRE_X:      centre_x_r <= cfg_wdata;
        REG_CENTRE_Y:      centre_y_r <= cfg_wdata;
        REG_HALF_EXTENT_X: half_x_r   <= cfg_wdata[W-2:0];
        REG_HALF_EXTENT_Y: half_y_r   <= cfg_wdata[W-2:0];
        default: ;
      endcase
    end
  end

  assign in_ctl = '{valid: in_tvalid, last: in_tlast};

  bod_offset #(.W(W)) u_offset (
    .clk        (clk),
    .rst_n      (rst_n),
    .centre_x   (centre_x_r),
    .centre_y   (centre_y_r),
    .half_x     (half_x_r),
    .half_y     (half_y_r),
    .up_ctl     (in_ctl),
    .up_ready   (in_tready),
    .point_x    (in_tdata[W-1:0]),
    .point_y    (in_tdata[2*W-1:W]),
    .dn_ctl     (off_ctl),
    .dn_ready   (off_ready),
    .dx         (dx),
    .dy         (dy)
  );

  bod_square_sum #(.W(W)) u_square_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_ctl   (off_ctl),
    .up_ready (off_ready),
    .dx       (dx),
    .dy       (dy),
    .dn_ctl   (sq_ctl),
    .dn_ready (sq_ready),
    .sum      (sum)
  );

  bod_sqrt #(.W(W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_ctl   (sq_ctl),
    .up_ready (sq_ready),
    .radicand (sum),
    .dn_ctl   (rt_ctl),
    .dn_ready (out_tready),
    .root     (distance)
  );

  // drive the result word from the last root stage
  assign out_tvalid = rt_ctl.valid;
  assign out_tlast  = rt_ctl.last;
  assign out_tdata  = OUT_TDATA_W'(distance);

endmodule
